// ----- sv/dqhnp_pkg.sv -----
// shared types and constants for the dns header and question name parser
// no dependencies
`default_nettype none

package dqhnp_pkg;

	localparam int MAX_NAME_DEFAULT = 255;
	localparam int NAME_LEN_W       = 10;
	localparam int HDR_IDX_W        = 4;

	localparam logic [HDR_IDX_W-1:0] HDR_IDX_FLAGS_END = HDR_IDX_W'(3);
	localparam logic [HDR_IDX_W-1:0] HDR_IDX_WORD1     = HDR_IDX_W'(8);
	localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST      = HDR_IDX_W'(11);

	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef enum logic [1:0] {
		KIND_HEADER   = 2'd0,
		KIND_CHAR     = 2'd1,
		KIND_END      = 2'd2,
		KIND_TOO_LONG = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_NAME   = 3'b010,
		PH_IGNORE = 3'b100
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  name_char;
		logic [15:0] query_id;
		logic        is_response;
		logic [3:0]  op_code;
		logic [3:0]  flag_bits;
		logic [3:0]  response_code;
		logic [15:0] question_count;
		logic [15:0] answer_count;
		logic [15:0] authority_count;
		logic [15:0] additional_count;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/dns_query_header_name_parser_top.sv -----
// DNS header and question name parser, one message byte per item. An accepted
// byte sits in an input register while the parser decodes it, and its result, if
// any, is loaded into the result register when the byte advances, which waits while
// the result register is full and not taken. One byte is taken every cycle while
// in_ready is high; in_ready drops only when both the input register and the result
// register hold items and the consumer is not taking the result.
// Depends on dqhnp_pkg, dqhnp_in_reg, dqhnp_parser, dqhnp_out_reg.
`default_nettype none

module dns_query_header_name_parser_top
	import dqhnp_pkg::*;
#(
	parameter int MAX_NAME = MAX_NAME_DEFAULT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_packet,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       out_kind,
	output logic [7:0]       name_char,
	output logic [15:0]      query_id,
	output logic             is_response,
	output logic [3:0]       op_code,
	output logic [3:0]       flag_bits,
	output logic [3:0]       response_code,
	output logic [15:0]      question_count,
	output logic [15:0]      answer_count,
	output logic [15:0]      authority_count,
	output logic [15:0]      additional_count
);

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       eop_s1;
	logic       slot_free;
	logic       advance;
	logic       has_result;
	result_t    result;
	result_t    out_data_q;

	assign advance = valid_s1 && slot_free;

	dqhnp_in_reg u_in_reg (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.data_byte     (data_byte),
		.end_of_packet (end_of_packet),
		.advance       (advance),
		.valid_s1      (valid_s1),
		.data_s1       (data_s1),
		.eop_s1        (eop_s1)
	);

	dqhnp_parser #(
		.MAX_NAME (MAX_NAME)
	) u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.data_byte     (data_s1),
		.end_of_packet (eop_s1),
		.has_result    (has_result),
		.result        (result)
	);

	dqhnp_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance),
		.load_valid (has_result),
		.load_data  (result),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.slot_free  (slot_free),
		.out_data_q (out_data_q)
	);

	assign out_kind         = out_data_q.kind;
	assign name_char        = out_data_q.name_char;
	assign query_id         = out_data_q.query_id;
	assign is_response      = out_data_q.is_response;
	assign op_code          = out_data_q.op_code;
	assign flag_bits        = out_data_q.flag_bits;
	assign response_code    = out_data_q.response_code;
	assign question_count   = out_data_q.question_count;
	assign answer_count     = out_data_q.answer_count;
	assign authority_count  = out_data_q.authority_count;
	assign additional_count = out_data_q.additional_count;

endmodule

`default_nettype wire

// ----- sv/dqhnp_in_reg.sv -----
// input register holding one accepted byte and its end flag
// depends on nothing beyond the handshake from the top level
`default_nettype none

module dqhnp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_packet,
	input  wire logic       advance,
	output logic            valid_s1,
	output logic [7:0]      data_s1,
	output logic            eop_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			eop_s1  <= end_of_packet;
		end
	end

endmodule

`default_nettype wire

// ----- sv/dqhnp_parser.sv -----
// message state and per-byte decode: header capture, name characters, limits
// depends on dqhnp_pkg
`default_nettype none

module dqhnp_parser
	import dqhnp_pkg::*;
#(
	parameter int MAX_NAME = MAX_NAME_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_packet,
	output logic            has_result,
	output result_t         result
);

	phase_t                 phase_q, phase_d;
	logic [HDR_IDX_W-1:0]   idx_q, idx_d;
	logic [63:0]            word0_q, word0_d, word0_shift;
	logic [31:0]            word1_q, word1_d, word1_shift;
	logic [7:0]             left_q, left_d;
	logic                   first_q, first_d;
	logic [NAME_LEN_W-1:0]  len_q, len_d;

	function automatic result_t make_header(input logic [15:0] id, input logic [15:0] fl,
		input logic [15:0] qd, input logic [15:0] an, input logic [15:0] ns,
		input logic [15:0] ar);
		result_t r;
		r                  = '0;
		r.kind             = KIND_HEADER;
		r.query_id         = id;
		r.is_response      = fl[15];
		r.op_code          = fl[14:11];
		r.flag_bits        = fl[10:7];
		r.response_code    = fl[3:0];
		r.question_count   = qd;
		r.answer_count     = an;
		r.authority_count  = ns;
		r.additional_count = ar;
		return r;
	endfunction

	assign word0_shift = {word0_q[55:0], data_byte};
	assign word1_shift = {word1_q[23:0], data_byte};

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		word0_d    = word0_q;
		word1_d    = word1_q;
		left_d     = left_q;
		first_d    = first_q;
		len_d      = len_q;
		has_result = 1'b0;
		result     = '0;
		case (phase_q)
			PH_HEADER: begin
				if (idx_q < HDR_IDX_WORD1) begin
					word0_d = word0_shift;
				end else begin
					word1_d = word1_shift;
				end
				if (idx_q == HDR_IDX_FLAGS_END) begin
					if (word0_shift[15]) begin
						has_result = 1'b1;
						result     = make_header(word0_shift[31:16], word0_shift[15:0],
							16'd0, 16'd0, 16'd0, 16'd0);
						phase_d    = PH_IGNORE;
					end
				end else if (idx_q == HDR_IDX_LAST) begin
					has_result = 1'b1;
					result     = make_header(word0_q[63:48], word0_q[47:32],
						word0_q[31:16], word0_q[15:0], word1_shift[31:16], word1_shift[15:0]);
					phase_d    = PH_NAME;
					left_d     = 8'd0;
					first_d    = 1'b1;
					len_d      = '0;
				end
				idx_d = idx_q + 1'b1;
			end
			PH_NAME: begin
				if (left_q == 8'd0) begin
					if (data_byte == 8'd0) begin
						has_result  = 1'b1;
						result.kind = KIND_END;
						phase_d     = PH_IGNORE;
					end else begin
						left_d  = data_byte;
						first_d = 1'b0;
						if (!first_q) begin
							has_result = 1'b1;
							if (len_q >= NAME_LEN_W'(MAX_NAME)) begin
								result.kind = KIND_TOO_LONG;
								phase_d     = PH_IGNORE;
							end else begin
								len_d            = len_q + 1'b1;
								result.kind      = KIND_CHAR;
								result.name_char = DOT_CHAR;
							end
						end
					end
				end else begin
					left_d     = left_q - 8'd1;
					has_result = 1'b1;
					if (len_q >= NAME_LEN_W'(MAX_NAME)) begin
						result.kind = KIND_TOO_LONG;
						phase_d     = PH_IGNORE;
					end else begin
						len_d            = len_q + 1'b1;
						result.kind      = KIND_CHAR;
						result.name_char = data_byte;
					end
				end
			end
			PH_IGNORE: begin
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
		if (end_of_packet) begin
			phase_d = PH_HEADER;
			idx_d   = '0;
			word0_d = '0;
			word1_d = '0;
			left_d  = 8'd0;
			first_d = 1'b1;
			len_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			idx_q   <= '0;
			word0_q <= '0;
			word1_q <= '0;
			left_q  <= 8'd0;
			first_q <= 1'b1;
			len_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			word0_q <= word0_d;
			word1_q <= word1_d;
			left_q  <= left_d;
			first_q <= first_d;
			len_q   <= len_d;
		end
	end

endmodule

`default_nettype wire

// ----- sv/dqhnp_out_reg.sv -----
// result register with valid and ready toward the consumer
// depends on dqhnp_pkg
`default_nettype none

module dqhnp_out_reg
	import dqhnp_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire logic    load_valid,
	input  wire result_t load_data,
	input  wire logic    out_ready,
	output logic         out_valid,
	output logic         slot_free,
	output result_t      out_data_q
);

	assign slot_free = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= load_valid;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			out_data_q <= load_data;
		end
	end

endmodule

`default_nettype wire

// ----- sv/dqhnp_checker.sv -----
// port-level checks on the parser result channel, bound to the top level
// depends on dqhnp_pkg and dns_query_header_name_parser_top
`default_nettype none

module dqhnp_checker
	import dqhnp_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  out_kind,
	input wire logic [7:0]  name_char,
	input wire logic [15:0] query_id,
	input wire logic        is_response,
	input wire logic [3:0]  op_code,
	input wire logic [3:0]  flag_bits,
	input wire logic [3:0]  response_code,
	input wire logic [15:0] question_count,
	input wire logic [15:0] answer_count,
	input wire logic [15:0] authority_count,
	input wire logic [15:0] additional_count
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(name_char)
			&& $stable(query_id))
		else $error("result changed while stalled");

	a_name_no_header: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_HEADER |-> query_id == 16'd0 && !is_response
			&& op_code == 4'd0 && flag_bits == 4'd0 && response_code == 4'd0
			&& question_count == 16'd0 && additional_count == 16'd0)
		else $error("header fields set on a name item");

	a_response_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == KIND_HEADER && is_response |-> question_count == 16'd0
			&& answer_count == 16'd0 && authority_count == 16'd0
			&& additional_count == 16'd0)
		else $error("response header with nonzero counts");

	a_char_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != KIND_CHAR |-> name_char == 8'd0)
		else $error("name character on a non-character item");

endmodule

bind dns_query_header_name_parser_top dqhnp_checker u_dqhnp_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.out_kind         (out_kind),
	.name_char        (name_char),
	.query_id         (query_id),
	.is_response      (is_response),
	.op_code          (op_code),
	.flag_bits        (flag_bits),
	.response_code    (response_code),
	.question_count   (question_count),
	.answer_count     (answer_count),
	.authority_count  (authority_count),
	.additional_count (additional_count)
);

`default_nettype wire
